/* hdl/mts_pkg.sv */
// ----------------------------------------------------------------------------
// Mipmap texture sampler package
// Shared types, register indexes, mode codes and helper functions.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int unsigned MAX_SIZE_LOG2_DEF = 8;
  localparam int unsigned MAX_LEVELS_DEF    = 9;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  localparam logic [1:0] LM_ZERO    = 2'd0;
  localparam logic [1:0] LM_NEAREST = 2'd1;
  localparam logic [1:0] LM_BLEND   = 2'd2;

  localparam logic [7:0] REG_LEVEL_MODE  = 8'd0;
  localparam logic [7:0] REG_PIXEL_MODE  = 8'd1;
  localparam logic [7:0] REG_WIDTH_LOG2  = 8'd2;
  localparam logic [7:0] REG_HEIGHT_LOG2 = 8'd3;

  typedef struct packed {
    logic        action;
    logic [3:0]  write_level;
    logic [7:0]  write_x;
    logic [7:0]  write_y;
    logic [23:0] write_rgb;
    logic [15:0] u;
    logic [15:0] v;
    logic [15:0] dx_u;
    logic [15:0] dx_v;
    logic [15:0] dy_u;
    logic [15:0] dy_v;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_item_t;

  typedef struct packed {
    logic [7:0] index;
    logic [7:0] value;
  } cfg_wr_t;

  typedef struct packed {
    logic [1:0] level_mode;
    logic       pixel_mode;
    logic [3:0] width_log2;
    logic [3:0] height_log2;
  } cfg_t;

  typedef enum logic [2:0] {
    F_IDLE, F_SQ, F_SUM, F_LZ1, F_LZ2, F_LOG, F_CLAMP, F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_READ, B_WAIT, B_LERP1, B_LERP2, B_BLEND
  } back_state_t;

  function automatic logic [3:0] sat_log2(input logic [3:0] r, input int unsigned m);
    return (int'(r) > int'(m)) ? 4'(m) : r;
  endfunction

  // Offset of a level in the store: levels are packed squares from level 0.
  function automatic logic [31:0] level_base(input logic [3:0] lvl, input int unsigned m);
    logic [31:0] off;
    off = '0;
    for (int k = 0; k < 16; k++) begin
      if (k < int'(lvl) && k <= int'(m)) off = off + (32'd1 << (2 * (int'(m) - k)));
    end
    return off;
  endfunction

endpackage

/* hdl/mts_chan_if.sv */
// ----------------------------------------------------------------------------
// Mipmap texture sampler channel
// Valid/ready channel carrying one payload struct per request.
// ----------------------------------------------------------------------------
interface mts_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/mts_fifo.sv */
// ----------------------------------------------------------------------------
// Mipmap texture sampler queue
// Small first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module mts_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  localparam int unsigned PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]    mem_r [DEPTH];
  logic [PTRW-1:0] wptr_r, rptr_r;
  logic [PTRW:0]   cnt_r;

  assign full  = (cnt_r == (PTRW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= (wptr_r == PTRW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      if (pop)  rptr_r <= (rptr_r == PTRW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end
endmodule

/* hdl/mts_front.sv */
// ----------------------------------------------------------------------------
// Mipmap texture sampler front
// Accepts requests, forms texel write addresses and computes the mip level.
// ----------------------------------------------------------------------------
module mts_front #(
  parameter int unsigned MAX_SIZE_LOG2 = mts_pkg::MAX_SIZE_LOG2_DEF,
  parameter int unsigned MAX_LEVELS    = mts_pkg::MAX_LEVELS_DEF,
  parameter int unsigned EW            = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  mts_pkg::cfg_t    cfg,
  input  logic             in_valid,
  input  mts_pkg::in_item_t in_data,
  output logic             in_ready,
  output logic             q_push,
  output logic [EW-1:0]    q_wdata,
  input  logic             q_full
);
  localparam int unsigned M    = MAX_SIZE_LOG2;
  localparam int unsigned AW   = 2 * M + 1;
  localparam int unsigned LVW  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int unsigned LQW  = LVW + 4;
  localparam int unsigned DW   = 17 + M;
  localparam int unsigned SQW  = 2 * (16 + M);
  localparam int unsigned SW   = SQW + 1;
  localparam int unsigned NG   = (SW + 7) / 8;
  localparam int unsigned PW   = NG * 8;
  localparam int unsigned LZW  = $clog2(PW) + 1;

  typedef struct packed {
    logic            is_wr;
    logic [AW-1:0]   addr;
    logic [23:0]     rgb;
    logic [15:0]     u;
    logic [15:0]     v;
    logic [LVW-1:0]  lo;
    logic [LVW-1:0]  hi;
    logic [3:0]      frac;
  } qent_t;

  mts_pkg::front_state_t state_r, state_nxt;

  logic signed [DW-1:0] d_r [4];
  logic [SQW-1:0]       sq_r [4];
  logic [PW-1:0]        s_r;
  logic [LZW-1:0]       lz_r;
  logic [31:0]          m_r;
  logic signed [11:0]   t_r;
  logic [1:0]           it_r;
  logic [15:0]          u_r, v_r;
  logic [LVW-1:0]       lo_r, hi_r;
  logic [3:0]           frac_r;

  logic [3:0]  wls, hls, mxl;
  int          nlev, top;
  logic        acc, is_sample, need_lvl;
  logic        wr_ok;
  int          wsh;
  logic [31:0] wbase;
  logic [AW-1:0] waddr;
  qent_t       ent;

  logic signed [DW-1:0]   d_nxt [4];
  logic signed [2*DW-1:0] sq_full [4];
  logic [SW-1:0]          sx, sy;
  int                     gi, pb;
  logic [LZW-1:0]         sh1;
  logic [PW-1:0]          norm;
  int                     t_calc;
  logic [63:0]            sqm;
  logic [32:0]            m2;
  logic [LQW-1:0]         lq;
  logic [LVW-1:0]         lq_lo;

  always_comb begin
    wls  = mts_pkg::sat_log2(cfg.width_log2, M);
    hls  = mts_pkg::sat_log2(cfg.height_log2, M);
    mxl  = (wls > hls) ? wls : hls;
    nlev = int'(mxl) + 1;
    if (nlev > int'(MAX_LEVELS)) nlev = int'(MAX_LEVELS);
    top  = (nlev - 1) * 16;
  end

  assign acc       = in_valid && in_ready;
  assign is_sample = (in_data.action == mts_pkg::ACT_SAMPLE);
  assign need_lvl  = cfg.level_mode inside {mts_pkg::LM_NEAREST, mts_pkg::LM_BLEND};

  // Texel write address and range check.
  always_comb begin
    wsh   = int'(M) - int'(in_data.write_level);
    wr_ok = (int'(in_data.write_level) < int'(MAX_LEVELS)) && (wsh >= 0) &&
            ((in_data.write_x >> wsh) == '0) && ((in_data.write_y >> wsh) == '0);
    wbase = mts_pkg::level_base(in_data.write_level, M);
    waddr = wbase[AW-1:0] + (AW'(in_data.write_y) << wsh) + AW'(in_data.write_x);
  end

  always_comb begin
    d_nxt[0] = (DW'($signed({1'b0, in_data.dx_u})) - DW'($signed({1'b0, in_data.u})))
               <<< wls;
    d_nxt[1] = (DW'($signed({1'b0, in_data.dx_v})) - DW'($signed({1'b0, in_data.v})))
               <<< hls;
    d_nxt[2] = (DW'($signed({1'b0, in_data.dy_u})) - DW'($signed({1'b0, in_data.u})))
               <<< wls;
    d_nxt[3] = (DW'($signed({1'b0, in_data.dy_v})) - DW'($signed({1'b0, in_data.v})))
               <<< hls;
    for (int i = 0; i < 4; i++) sq_full[i] = d_r[i] * d_r[i];
    sx = {1'b0, sq_r[0]} + {1'b0, sq_r[1]};
    sy = {1'b0, sq_r[2]} + {1'b0, sq_r[3]};
  end

  // Normalization: first the top nonzero byte, then the top bit in it.
  always_comb begin
    gi = 0;
    for (int g = 0; g < int'(NG); g++) begin
      if (|s_r[g*8 +: 8]) gi = g;
    end
    sh1 = LZW'((int'(NG) - 1 - gi) * 8);
    pb = 0;
    for (int b = 0; b < 8; b++) begin
      if (s_r[PW-8+b]) pb = b;
    end
    norm   = s_r << (7 - pb);
    t_calc = (int'(PW) - 1 - int'(lz_r) - (7 - pb) - 32) * 8;
    sqm    = 64'(m_r) * 64'(m_r);
    m2     = sqm[63:31];
    if (t_r < 0) lq = '0;
    else if (int'(t_r) > top) lq = LQW'(top);
    else lq = LQW'(t_r);
    lq_lo = lq[LQW-1:4];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mts_pkg::F_IDLE:  if (acc && is_sample) state_nxt = need_lvl ? mts_pkg::F_SQ
                                                                  : mts_pkg::F_PUSH;
      mts_pkg::F_SQ:    state_nxt = mts_pkg::F_SUM;
      mts_pkg::F_SUM:   state_nxt = mts_pkg::F_LZ1;
      mts_pkg::F_LZ1:   state_nxt = (s_r == '0) ? mts_pkg::F_PUSH : mts_pkg::F_LZ2;
      mts_pkg::F_LZ2:   state_nxt = mts_pkg::F_LOG;
      mts_pkg::F_LOG:   if (it_r == 2'd0) state_nxt = mts_pkg::F_CLAMP;
      mts_pkg::F_CLAMP: state_nxt = mts_pkg::F_PUSH;
      mts_pkg::F_PUSH:  if (!q_full) state_nxt = mts_pkg::F_IDLE;
      default:          state_nxt = mts_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    q_push   = 1'b0;
    ent      = '0;
    case (state_r)
      mts_pkg::F_IDLE: begin
        in_ready  = !q_full;
        q_push    = acc && !is_sample && wr_ok;
        ent.is_wr = 1'b1;
        ent.addr  = waddr;
        ent.rgb   = in_data.write_rgb;
      end
      mts_pkg::F_PUSH: begin
        q_push   = !q_full;
        ent.u    = u_r;
        ent.v    = v_r;
        ent.lo   = lo_r;
        ent.hi   = hi_r;
        ent.frac = frac_r;
      end
      default: ;
    endcase
    q_wdata = EW'(ent);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= mts_pkg::F_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      mts_pkg::F_IDLE: begin
        if (acc && is_sample) begin
          u_r    <= in_data.u;
          v_r    <= in_data.v;
          lo_r   <= '0;
          hi_r   <= '0;
          frac_r <= '0;
          for (int i = 0; i < 4; i++) d_r[i] <= d_nxt[i];
        end
      end
      mts_pkg::F_SQ: for (int i = 0; i < 4; i++) sq_r[i] <= sq_full[i][SQW-1:0];
      mts_pkg::F_SUM: s_r <= PW'((sx > sy) ? sx : sy);
      mts_pkg::F_LZ1: begin
        s_r  <= s_r << sh1;
        lz_r <= sh1;
      end
      mts_pkg::F_LZ2: begin
        m_r  <= norm[PW-1 -: 32];
        t_r  <= 12'(t_calc);
        it_r <= 2'd2;
      end
      mts_pkg::F_LOG: begin
        // Each squaring doubles the log; a mantissa of two or more gives a one bit.
        if (m2[32]) begin
          m_r <= m2[32:1];
          t_r <= t_r + $signed({9'b0, 3'(3'd1 << it_r)});
        end else begin
          m_r <= m2[31:0];
        end
        it_r <= it_r - 2'd1;
      end
      mts_pkg::F_CLAMP: begin
        lo_r   <= lq_lo;
        frac_r <= lq[3:0];
        hi_r   <= (int'(lq_lo) + 1 < nlev) ? lq_lo + 1'b1 : lq_lo;
      end
      default: ;
    endcase
  end
endmodule

/* hdl/mts_back.sv */
// ----------------------------------------------------------------------------
// Mipmap texture sampler back
// Holds the texel store, fetches texels and filters within and across levels.
// ----------------------------------------------------------------------------
module mts_back #(
  parameter int unsigned MAX_SIZE_LOG2 = mts_pkg::MAX_SIZE_LOG2_DEF,
  parameter int unsigned MAX_LEVELS    = mts_pkg::MAX_LEVELS_DEF,
  parameter int unsigned EW            = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mts_pkg::cfg_t      cfg,
  input  logic [EW-1:0]      q_rdata,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_valid,
  output mts_pkg::out_item_t out_data,
  input  logic               out_ready
);
  localparam int unsigned M     = MAX_SIZE_LOG2;
  localparam int unsigned AW    = 2 * M + 1;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned LVW   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

  typedef struct packed {
    logic            is_wr;
    logic [AW-1:0]   addr;
    logic [23:0]     rgb;
    logic [15:0]     u;
    logic [15:0]     v;
    logic [LVW-1:0]  lo;
    logic [LVW-1:0]  hi;
    logic [3:0]      frac;
  } qent_t;

  typedef struct packed {
    logic [M-1:0] i0;
    logic [M-1:0] i1;
    logic [M-1:0] near;
    logic [7:0]   fw;
  } axis_t;

  // Corner pair and weight along one axis; corners clamp to the level edge.
  function automatic axis_t axis_f(input logic [15:0] c, input logic [3:0] lg);
    logic [16+M:0] q;
    logic [16+M:0] p;
    logic [M:0]    ip, hi, x0, x1;
    axis_t         r;
    q      = (17+M)'(c) << lg;
    p      = q + (17+M)'(32768);
    ip     = p[16+M:16];
    hi     = (M+1)'((1 << lg) - 1);
    x0     = (ip == '0) ? '0 : ip - 1'b1;
    if (x0 > hi) x0 = hi;
    x1     = (ip > hi) ? hi : ip;
    r.i0   = x0[M-1:0];
    r.i1   = x1[M-1:0];
    r.near = q[15+M:16];
    r.fw   = p[15:8];
    return r;
  endfunction

  mts_pkg::back_state_t state_r, state_nxt;

  logic [23:0]    mem [DEPTH];
  logic [23:0]    rdata_r;
  logic           rd_vld_r;
  logic [1:0]     tag_r;
  logic [23:0]    c_r [4];
  qent_t          ent_r;
  logic           pass_r;
  logic [1:0]     idx_r;
  logic [15:0]    top_r [3];
  logic [15:0]    bot_r [3];
  logic [23:0]    res_r [2];
  logic           out_valid_r;
  mts_pkg::out_item_t out_r;

  qent_t          head;
  logic           bil, blend, can_out, wr_en, rd_en;
  logic [1:0]     last_idx;
  logic [3:0]     wls, hls, lw, lh, lvl4;
  logic [LVW-1:0] lvl;
  axis_t          ax, ay;
  logic [M-1:0]   xs, ys;
  logic [31:0]    rbase;
  logic [AW-1:0]  rd_addr;
  logic [8:0]     wx0, wx1, wy0, wy1;
  logic [23:0]    k00, k10, k01, k11;
  logic [15:0]    top_n [3];
  logic [15:0]    bot_n [3];
  logic [24:0]    val_full;
  logic [23:0]    val;
  logic [3:0]     bf;
  logic [23:0]    ba, bb;
  logic [12:0]    bsum;
  mts_pkg::out_item_t blend_px;

  assign head     = qent_t'(q_rdata);
  assign bil      = cfg.pixel_mode;
  assign blend    = (cfg.level_mode == mts_pkg::LM_BLEND);
  assign last_idx = bil ? 2'd3 : 2'd0;
  assign can_out  = !out_valid_r || out_ready;

  always_comb begin
    wls  = mts_pkg::sat_log2(cfg.width_log2, M);
    hls  = mts_pkg::sat_log2(cfg.height_log2, M);
    lvl  = pass_r ? ent_r.hi : ent_r.lo;
    lvl4 = 4'(lvl);
    lw   = (wls > lvl4) ? wls - lvl4 : 4'd0;
    lh   = (hls > lvl4) ? hls - lvl4 : 4'd0;
    ax   = axis_f(ent_r.u, lw);
    ay   = axis_f(ent_r.v, lh);
    if (bil) begin
      xs = idx_r[0] ? ax.i1 : ax.i0;
      ys = idx_r[1] ? ay.i1 : ay.i0;
    end else begin
      xs = ax.near;
      ys = ay.near;
    end
    rbase   = mts_pkg::level_base(lvl4, M);
    rd_addr = rbase[AW-1:0] + (AW'(ys) << (int'(M) - int'(lvl4))) + AW'(xs);
  end

  // Nearest filtering gives the one texel it reads the full weight.
  always_comb begin
    wx1 = bil ? {1'b0, ax.fw} : 9'd0;
    wy1 = bil ? {1'b0, ay.fw} : 9'd0;
    wx0 = 9'd256 - wx1;
    wy0 = 9'd256 - wy1;
    k00 = c_r[0];
    k10 = bil ? c_r[1] : c_r[0];
    k01 = bil ? c_r[2] : c_r[0];
    k11 = bil ? c_r[3] : c_r[0];
    val = '0;
    for (int ch = 0; ch < 3; ch++) begin
      top_n[ch] = 16'(17'(k00[16-8*ch +: 8]) * 17'(wx0) + 17'(k10[16-8*ch +: 8]) * 17'(wx1));
      bot_n[ch] = 16'(17'(k01[16-8*ch +: 8]) * 17'(wx0) + 17'(k11[16-8*ch +: 8]) * 17'(wx1));
      val_full  = 25'(top_r[ch]) * 25'(wy0) + 25'(bot_r[ch]) * 25'(wy1) + 25'd32768;
      val[16-8*ch +: 8] = val_full[23:16];
    end
  end

  always_comb begin
    bf = blend ? ent_r.frac : 4'd0;
    ba = res_r[0];
    bb = blend ? res_r[1] : res_r[0];
    blend_px = '0;
    bsum = '0;
    for (int ch = 0; ch < 3; ch++) begin
      bsum = 13'(ba[16-8*ch +: 8]) * 13'(5'd16 - {1'b0, bf}) +
             13'(bb[16-8*ch +: 8]) * 13'(bf) + 13'd8;
      case (ch)
        0:       blend_px.red   = bsum[11:4];
        1:       blend_px.green = bsum[11:4];
        default: blend_px.blue  = bsum[11:4];
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mts_pkg::B_IDLE:  if (!q_empty && !head.is_wr) state_nxt = mts_pkg::B_READ;
      mts_pkg::B_READ:  if (idx_r == last_idx) state_nxt = mts_pkg::B_WAIT;
      mts_pkg::B_WAIT:  state_nxt = mts_pkg::B_LERP1;
      mts_pkg::B_LERP1: state_nxt = mts_pkg::B_LERP2;
      mts_pkg::B_LERP2: state_nxt = (blend && !pass_r) ? mts_pkg::B_READ : mts_pkg::B_BLEND;
      mts_pkg::B_BLEND: if (can_out) state_nxt = mts_pkg::B_IDLE;
      default:          state_nxt = mts_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    wr_en = 1'b0;
    rd_en = 1'b0;
    case (state_r)
      mts_pkg::B_IDLE: begin
        q_pop = !q_empty;
        wr_en = !q_empty && head.is_wr;
      end
      mts_pkg::B_READ: rd_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[head.addr] <= head.rgb;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mts_pkg::B_IDLE;
      pass_r      <= 1'b0;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en;
      case (state_r)
        mts_pkg::B_IDLE: begin
          pass_r <= 1'b0;
          idx_r  <= '0;
        end
        mts_pkg::B_READ:  if (idx_r != last_idx) idx_r <= idx_r + 2'd1;
        mts_pkg::B_LERP2: begin
          idx_r <= '0;
          if (blend && !pass_r) pass_r <= 1'b1;
        end
        default: ;
      endcase
      if (state_r == mts_pkg::B_BLEND && can_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= idx_r;
    if (rd_vld_r) c_r[tag_r] <= rdata_r;
    if (state_r == mts_pkg::B_IDLE && !q_empty && !head.is_wr) ent_r <= head;
    if (state_r == mts_pkg::B_LERP1) begin
      for (int ch = 0; ch < 3; ch++) begin
        top_r[ch] <= top_n[ch];
        bot_r[ch] <= bot_n[ch];
      end
    end
    if (state_r == mts_pkg::B_LERP2) res_r[pass_r] <= val;
    if (state_r == mts_pkg::B_BLEND && can_out) out_r <= blend_px;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule

/* hdl/mipmap_texture_sampler_top.sv */
// ----------------------------------------------------------------------------
// Mipmap texture sampler
// Mipmapped RGB888 texture store with nearest, bilinear and trilinear sampling.
// ----------------------------------------------------------------------------
//  port    dir   payload      purpose
//  in_ch   sink  in_item_t    texel write or sample request
//  out_ch  src   out_item_t   filtered color, one per sample
//  cfg_ch  sink  cfg_wr_t     register write, always ready
//
// A write that lands in the store is queued by the front and written by the
// back. In the back, a sample reads N texels (1 or 4) from each of P levels
// (1 or 2), one at a time over the single read port of the texel store. The
// front computes the level, clamps it and queues the sample. Reset clears
// control state only; the texel store holds no reset value. The four-entry
// queue and the output register let either side stall on its own.
module mipmap_texture_sampler_top #(
  parameter int unsigned MAX_SIZE_LOG2 = mts_pkg::MAX_SIZE_LOG2_DEF,
  parameter int unsigned MAX_LEVELS    = mts_pkg::MAX_LEVELS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  mts_chan_if.sink   in_ch,
  mts_chan_if.source out_ch,
  mts_chan_if.sink   cfg_ch
);
  localparam int unsigned AW  = 2 * MAX_SIZE_LOG2 + 1;
  localparam int unsigned LVW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int unsigned EW  = 1 + AW + 24 + 32 + 2 * LVW + 4;

  mts_pkg::cfg_t cfg_r;
  mts_pkg::cfg_wr_t cfg_req;
  logic          q_push, q_full, q_pop, q_empty;
  logic [EW-1:0] q_wdata, q_rdata;

  assign cfg_ch.ready = 1'b1;
  assign cfg_req      = cfg_ch.data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.level_mode  <= mts_pkg::LM_ZERO;
      cfg_r.pixel_mode  <= 1'b0;
      cfg_r.width_log2  <= 4'd8;
      cfg_r.height_log2 <= 4'd8;
    end else if (cfg_ch.valid) begin
      case (cfg_req.index)
        mts_pkg::REG_LEVEL_MODE:  cfg_r.level_mode  <= cfg_req.value[1:0];
        mts_pkg::REG_PIXEL_MODE:  cfg_r.pixel_mode  <= cfg_req.value[0];
        mts_pkg::REG_WIDTH_LOG2:  cfg_r.width_log2  <= cfg_req.value[3:0];
        mts_pkg::REG_HEIGHT_LOG2: cfg_r.height_log2 <= cfg_req.value[3:0];
        default: ;
      endcase
    end
  end

  mts_front #(
    .MAX_SIZE_LOG2(MAX_SIZE_LOG2), .MAX_LEVELS(MAX_LEVELS), .EW(EW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_ch.valid),
    .in_data  (in_ch.data),
    .in_ready (in_ch.ready),
    .q_push   (q_push),
    .q_wdata  (q_wdata),
    .q_full   (q_full)
  );

  mts_fifo #(.W(EW), .DEPTH(4)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  mts_back #(
    .MAX_SIZE_LOG2(MAX_SIZE_LOG2), .MAX_LEVELS(MAX_LEVELS), .EW(EW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_rdata   (q_rdata),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_ch.valid),
    .out_data  (out_ch.data),
    .out_ready (out_ch.ready)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("queue pushed while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("queue popped while empty");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result dropped or changed while stalled");
endmodule

/* bench/mts_sample_checker.sv */
// ----------------------------------------------------------------------------
// Mipmap texture sampler checker
// Watches the request, result and register channels. It keeps its own copy
// of the texel store and the registers, predicts the color of every sample
// request and compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module mts_sample_checker
  import mts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  cfg_wr_t   cfg_data,
  output int        fail_count,
  output int        pending
);

  localparam int unsigned SIDE_LOG2  = 8;
  localparam int unsigned NUM_LEVELS = 9;
  localparam int unsigned DEPTH      = 2 << (2 * SIDE_LOG2);

  logic [23:0] texels [DEPTH];
  cfg_t        regs;
  out_item_t   color_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic int unsigned clamp_size(logic [3:0] r);
    return (r > SIDE_LOG2) ? SIDE_LOG2 : int'(r);
  endfunction

  function automatic int unsigned lvl_offset(int unsigned lvl);
    int unsigned off;
    off = 0;
    for (int unsigned k = 0; k < lvl; k++) off += 1 << (2 * (SIDE_LOG2 - k));
    return off;
  endfunction

  function automatic logic [23:0] texel_at(int unsigned lvl, int unsigned x, int unsigned y);
    int unsigned a;
    a = lvl_offset(lvl) + (y << (SIDE_LOG2 - lvl)) + x;
    return (a < DEPTH) ? texels[a] : 24'd0;
  endfunction

  function automatic int unsigned chan(logic [23:0] c, int k);
    return (c >> (16 - 8 * k)) & 24'hFF;
  endfunction

  // Corner pair along one axis, clamped to the level edge, and its 8-bit weight.
  function automatic void corner_axis(logic [15:0] c, int unsigned lg, output int unsigned i0,
                                      output int unsigned i1, output int unsigned fw);
    logic [31:0] p;
    int          x0, x1, hi;
    p  = ({16'd0, c} << lg) + 32'd32768;
    x0 = int'(p >> 16) - 1;
    x1 = x0 + 1;
    hi = (1 << lg) - 1;
    fw = p[15:8];
    if (x0 < 0) x0 = 0;
    if (x0 > hi) x0 = hi;
    if (x1 > hi) x1 = hi;
    i0 = x0;
    i1 = x1;
  endfunction

  function automatic logic [23:0] filter_level(int unsigned lvl, logic [15:0] u, logic [15:0] v,
                                               logic bil);
    int unsigned wl, hl, lw, lh, x0, x1, y0, y1, fx, fy, top, bot, val;
    logic [23:0] c00, c10, c01, c11, res;
    wl = clamp_size(regs.width_log2);
    hl = clamp_size(regs.height_log2);
    lw = (wl > lvl) ? wl - lvl : 0;
    lh = (hl > lvl) ? hl - lvl : 0;
    if (!bil) return texel_at(lvl, (int'(u) << lw) >> 16, (int'(v) << lh) >> 16);
    corner_axis(u, lw, x0, x1, fx);
    corner_axis(v, lh, y0, y1, fy);
    c00 = texel_at(lvl, x0, y0);
    c10 = texel_at(lvl, x1, y0);
    c01 = texel_at(lvl, x0, y1);
    c11 = texel_at(lvl, x1, y1);
    res = '0;
    for (int k = 0; k < 3; k++) begin
      top = chan(c00, k) * (256 - fx) + chan(c10, k) * fx;
      bot = chan(c01, k) * (256 - fx) + chan(c11, k) * fx;
      val = (top * (256 - fy) + bot * fy + 32768) >> 16;
      res |= (val & 8'hFF) << (16 - 8 * k);
    end
    return res;
  endfunction

  // Mip level in 1/16 steps from the longer screen footprint, clamped.
  function automatic int footprint_level_q4(in_item_t it, int unsigned nlev);
    longint      xu, xv, yu, yv;
    logic [63:0] sx, sy, s, m;
    int          msb, t, top;
    int unsigned wl, hl;
    wl  = clamp_size(regs.width_log2);
    hl  = clamp_size(regs.height_log2);
    xu  = (longint'(it.dx_u) - longint'(it.u)) * (longint'(1) << wl);
    xv  = (longint'(it.dx_v) - longint'(it.v)) * (longint'(1) << hl);
    yu  = (longint'(it.dy_u) - longint'(it.u)) * (longint'(1) << wl);
    yv  = (longint'(it.dy_v) - longint'(it.v)) * (longint'(1) << hl);
    sx  = xu * xu + xv * xv;
    sy  = yu * yu + yv * yv;
    s   = (sx > sy) ? sx : sy;
    top = (int'(nlev) - 1) * 16;
    if (s == 0) return 0;
    msb = 63;
    while (!s[msb]) msb--;
    m = (msb >= 31) ? (s >> (msb - 31)) : (s << (31 - msb));
    t = (msb - 32) * 8;
    for (int i = 2; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        t += 1 << i;
        m = m >> 1;
      end
    end
    if (t < 0) t = 0;
    if (t > top) t = top;
    return t;
  endfunction

  function automatic out_item_t predict_color(in_item_t it);
    int unsigned wl, hl, nlev, lo, hi, f, ch;
    int          lq;
    logic [23:0] a, b, c;
    out_item_t   o;
    wl   = clamp_size(regs.width_log2);
    hl   = clamp_size(regs.height_log2);
    nlev = ((wl > hl) ? wl : hl) + 1;
    if (nlev > NUM_LEVELS) nlev = NUM_LEVELS;
    if (regs.level_mode == LM_NEAREST || regs.level_mode == LM_BLEND) begin
      lq = footprint_level_q4(it, nlev);
      lo = lq >> 4;
      f  = lq & 15;
      if (regs.level_mode == LM_NEAREST) begin
        c = filter_level(lo, it.u, it.v, regs.pixel_mode);
      end else begin
        hi = (lo + 1 < nlev) ? lo + 1 : lo;
        a  = filter_level(lo, it.u, it.v, regs.pixel_mode);
        b  = filter_level(hi, it.u, it.v, regs.pixel_mode);
        c  = '0;
        for (int k = 0; k < 3; k++) begin
          ch = (chan(a, k) * (16 - f) + chan(b, k) * f + 8) >> 4;
          c |= (ch & 8'hFF) << (16 - 8 * k);
        end
      end
    end else begin
      c = filter_level(0, it.u, it.v, regs.pixel_mode);
    end
    o.red   = c[23:16];
    o.green = c[15:8];
    o.blue  = c[7:0];
    return o;
  endfunction

  task automatic note_mismatch(string what, out_item_t exp_c, out_item_t act_c);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch (%s): expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d", what,
               exp_c.red, exp_c.green, exp_c.blue, act_c.red, act_c.green, act_c.blue);
  endtask

  always @(posedge clk) begin
    int unsigned lvl, a;
    out_item_t   exp_c;
    if (!rst_n) begin
      regs.level_mode  = LM_ZERO;
      regs.pixel_mode  = 1'b0;
      regs.width_log2  = 4'd8;
      regs.height_log2 = 4'd8;
      color_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_data.index)
          REG_LEVEL_MODE:  regs.level_mode  = cfg_data.value[1:0];
          REG_PIXEL_MODE:  regs.pixel_mode  = cfg_data.value[0];
          REG_WIDTH_LOG2:  regs.width_log2  = cfg_data.value[3:0];
          REG_HEIGHT_LOG2: regs.height_log2 = cfg_data.value[3:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_data.action == ACT_WRITE) begin
          lvl = in_data.write_level;
          if (lvl < NUM_LEVELS && lvl <= SIDE_LOG2 &&
              (in_data.write_x >> (SIDE_LOG2 - lvl)) == 0 &&
              (in_data.write_y >> (SIDE_LOG2 - lvl)) == 0) begin
            a = lvl_offset(lvl) + (int'(in_data.write_y) << (SIDE_LOG2 - lvl)) + in_data.write_x;
            if (a < DEPTH) texels[a] = in_data.write_rgb;
          end
        end else begin
          color_q.push_back(predict_color(in_data));
        end
      end
      if (out_valid && out_ready) begin
        if (color_q.size() == 0) begin
          note_mismatch("no sample outstanding", '0, out_data);
        end else begin
          exp_c = color_q.pop_front();
          if (exp_c.red != out_data.red || exp_c.green != out_data.green ||
              exp_c.blue != out_data.blue)
            note_mismatch("color", exp_c, out_data);
        end
      end
    end
    pending = color_q.size();
  end

endmodule

/* bench/mipmap_texture_sampler_top_tb.sv */
// ----------------------------------------------------------------------------
// Mipmap texture sampler testbench
// Loads every texel that a register setting can reach, then sends directed
// and random sample requests across all level and pixel modes and size
// settings, with random stalls on both sides and one long result hold-off.
// ----------------------------------------------------------------------------
module mipmap_texture_sampler_top_tb;
  import mts_pkg::*;

  localparam int unsigned SIDE_LOG2  = 8;
  localparam int          N_PHASES   = 10;
  localparam int          PER_PHASE  = 20;
  localparam int          SETTLE     = 40;
  localparam int          LIMIT      = 1000000;

  typedef struct {
    int lm;
    int pm;
    int w;
    int h;
  } phase_t;

  logic clk;
  logic rst_n;
  int   cycles;
  int   snd_idle;
  int   rcv_idle;
  int   rcv_hold;
  int   chk_fail;
  int   chk_pending;
  bit   loaded [2 << (2 * SIDE_LOG2)];
  phase_t plan [N_PHASES];

  mts_chan_if #(.T(in_item_t))  in_ch  ();
  mts_chan_if #(.T(out_item_t)) out_ch ();
  mts_chan_if #(.T(cfg_wr_t))   cfg_ch ();

  mipmap_texture_sampler_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  mts_sample_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_data    (in_ch.data),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_data   (out_ch.data),
    .cfg_valid  (cfg_ch.valid),
    .cfg_ready  (cfg_ch.ready),
    .cfg_data   (cfg_ch.data),
    .fail_count (chk_fail),
    .pending    (chk_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    cycles       = 0;
    snd_idle     = 0;
    rcv_idle     = 0;
    rcv_hold     = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (rcv_hold > 0) begin
      out_ch.ready <= 1'b0;
      rcv_hold = rcv_hold - 1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  function automatic int unsigned sat_size(int r);
    return (r > SIDE_LOG2) ? SIDE_LOG2 : r;
  endfunction

  function automatic int unsigned store_addr(int unsigned lvl, int unsigned x, int unsigned y);
    int unsigned off;
    off = 0;
    for (int unsigned k = 0; k < lvl; k++) off += 1 << (2 * (SIDE_LOG2 - k));
    return off + (y << (SIDE_LOG2 - lvl)) + x;
  endfunction

  // A neighbor coordinate a random distance away, up to a random power of two.
  function automatic logic [15:0] near(logic [15:0] c);
    int k;
    int d;
    k = $urandom_range(0, 15);
    d = $urandom_range(0, 1 << k);
    return ($urandom_range(0, 1) != 0) ? c + 16'(d) : c - 16'(d);
  endfunction

  task automatic send(in_item_t it);
    if (snd_idle > 0 && $urandom_range(0, 99) < snd_idle) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic cfg_write(logic [7:0] idx, int val);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.data.index <= idx;
    cfg_ch.data.value <= 8'(val);
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_texel(int unsigned lvl, int unsigned x, int unsigned y);
    in_item_t it;
    it             = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    it.action      = ACT_WRITE;
    it.write_level = 4'(lvl);
    it.write_x     = 8'(x);
    it.write_y     = 8'(y);
    send(it);
    loaded[store_addr(lvl, x, y)] = 1'b1;
  endtask

  // Writes every texel not yet loaded in the levels that the given size can reach.
  task automatic fill_levels(int w, int h);
    int unsigned ws, hs, nlev, lw, lh;
    ws   = sat_size(w);
    hs   = sat_size(h);
    nlev = ((ws > hs) ? ws : hs) + 1;
    for (int unsigned l = 0; l < nlev; l++) begin
      lw = (ws > l) ? ws - l : 0;
      lh = (hs > l) ? hs - l : 0;
      for (int unsigned y = 0; y < (1 << lh); y++)
        for (int unsigned x = 0; x < (1 << lw); x++)
          if (!loaded[store_addr(l, x, y)]) write_texel(l, x, y);
    end
  endtask

  task automatic sample(logic [15:0] u, logic [15:0] v, logic [15:0] xu, logic [15:0] xv,
                        logic [15:0] yu, logic [15:0] yv);
    in_item_t it;
    it        = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    it.action = ACT_SAMPLE;
    it.u      = u;
    it.v      = v;
    it.dx_u   = xu;
    it.dx_v   = xv;
    it.dy_u   = yu;
    it.dy_v   = yv;
    send(it);
  endtask

  task automatic stray_write(int lvl, int x, int y);
    in_item_t it;
    it             = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    it.action      = ACT_WRITE;
    it.write_level = 4'(lvl);
    it.write_x     = 8'(x);
    it.write_y     = 8'(y);
    send(it);
  endtask

  task automatic random_part(int w, int h);
    int unsigned ws, hs, nlev, l, lw, lh;
    logic [15:0] u, v;
    int          r, done;
    ws   = sat_size(w);
    hs   = sat_size(h);
    nlev = ((ws > hs) ? ws : hs) + 1;
    done = 0;
    while (done < PER_PHASE) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        l  = $urandom_range(0, nlev - 1);
        lw = (ws > l) ? ws - l : 0;
        lh = (hs > l) ? hs - l : 0;
        write_texel(l, $urandom_range(0, (1 << lw) - 1), $urandom_range(0, (1 << lh) - 1));
      end else if (r < 12) begin
        // Writes that land outside the store are dropped by the block.
        if ($urandom_range(0, 1) != 0) begin
          stray_write($urandom_range(9, 15), $urandom_range(0, 255), $urandom_range(0, 255));
        end else begin
          l = $urandom_range(1, SIDE_LOG2);
          stray_write(l, $urandom_range(1 << (SIDE_LOG2 - l), 255), $urandom_range(0, 255));
        end
      end else begin
        u = 16'($urandom);
        v = 16'($urandom);
        if (r < 22)
          sample(u, v, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        else if (r < 26)
          sample(u, v, u, v, u, v);
        else
          sample(u, v, near(u), near(v), near(u), near(v));
        done++;
      end
    end
  endtask

  initial begin
    plan[0] = '{2, 1, 3, 2};
    plan[1] = '{3, 1, 2, 3};
    plan[2] = '{1, 0, 3, 3};
    plan[3] = '{2, 1, 3, 3};
    plan[4] = '{2, 0, 8, 0};
    plan[5] = '{1, 1, 2, 4};
    plan[6] = '{0, 1, 0, 0};
    plan[7] = '{2, 1, 15, 0};
    plan[8] = '{2, 0, 1, 3};
    plan[9] = '{0, 0, 3, 3};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    for (int p = 0; p < N_PHASES; p++) begin
      if (p < 4) begin
        snd_idle = 28;
        rcv_idle = 75;
      end else if (p < 7) begin
        snd_idle = 75;
        rcv_idle = 28;
      end else begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      cfg_write(REG_LEVEL_MODE, plan[p].lm);
      cfg_write(REG_PIXEL_MODE, plan[p].pm);
      cfg_write(REG_WIDTH_LOG2, plan[p].w);
      cfg_write(REG_HEIGHT_LOG2, plan[p].h);
      cfg_ch.valid <= 1'b0;
      fill_levels(plan[p].w, plan[p].h);
      if (p == 0) begin
        sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        sample(16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
        sample(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        sample(16'h8000, 16'h8000, 16'h8001, 16'h8000, 16'h8000, 16'h8001);
        sample(16'h1000, 16'hF000, 16'h1800, 16'hF000, 16'h1000, 16'hE800);
        sample(16'h7FFF, 16'h0001, 16'h9FFF, 16'h0001, 16'h7FFF, 16'h2001);
        stray_write(15, 255, 255);
        stray_write(9, 0, 0);
        stray_write(2, 64, 0);
        stray_write(8, 1, 0);
        stray_write(1, 0, 128);
        write_texel(0, 0, 0);
        write_texel(8, 0, 0);
        sample(16'h0000, 16'h0000, 16'h0400, 16'h0000, 16'h0000, 16'h0000);
      end
      if (p == 7) begin
        // Hold results back long enough for the block to fill and stall.
        rcv_hold = 400;
      end
      random_part(plan[p].w, plan[p].h);
      drain();
    end

    if (chk_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/mts_pkg.sv
hdl/mts_chan_if.sv
hdl/mts_fifo.sv
hdl/mts_front.sv
hdl/mts_back.sv
hdl/mipmap_texture_sampler_top.sv
bench/mts_sample_checker.sv
bench/mipmap_texture_sampler_top_tb.sv
